// ===== rtl/core/orwp_pkg.sv =====
// Shared types and constants for the OLED region write packer.
// No dependencies; compiled first.
package orwp_pkg;

   // Controller opcodes for the window header
   localparam logic [7:0] OP_ROW_WINDOW = 8'h75;
   localparam logic [7:0] OP_COL_WINDOW = 8'h15;
   localparam logic [7:0] OP_WRITE_RAM  = 8'h5c;

   // Request command codes
   localparam logic CMD_REGION = 1'b0;
   localparam logic CMD_PIXEL  = 1'b1;

   localparam logic [6:0] COLUMN_OFFSET_RESET = 7'd28;

   localparam int MAX_COLUMNS_DEFAULT = 256;
   localparam int MAX_ROWS_DEFAULT    = 128;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // Header byte sequencer steps
   typedef enum logic [2:0] {
      STEP_ROW_CMD,
      STEP_ROW_FIRST,
      STEP_ROW_LAST,
      STEP_COL_CMD,
      STEP_COL_FIRST,
      STEP_COL_LAST,
      STEP_WRITE_RAM
   } hdr_step_type;

   // One queued job: either a whole window header or one data byte
   typedef struct packed {
      logic       is_header;
      logic [6:0] row_first;
      logic [6:0] row_last;
      logic [7:0] col_first;
      logic [7:0] col_last;
      logic [7:0] data_byte;
      logic       last;
   } orwp_entry_type;

   // Queue status seen by the back end and the request handshake
   typedef struct packed {
      logic empty;
      logic full;
   } orwp_qstat_type;

endpackage

// ===== rtl/core/orwp_if.sv =====
// Channel interfaces for the OLED region write packer: request, response, csr write.
// Depends on nothing; compiled after orwp_pkg.
interface orwp_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] x_first;
   logic [7:0] x_last;
   logic [6:0] y_first;
   logic [6:0] y_last;
   logic [7:0] pixel_value;
   modport source (output valid, cmd, x_first, x_last, y_first, y_last, pixel_value,
                   input ready);
   modport sink   (input valid, cmd, x_first, x_last, y_first, y_last, pixel_value,
                   output ready);
endinterface

interface orwp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       is_data;
   logic       last;
   modport source (output valid, out_byte, is_data, last, input ready);
   modport sink   (input valid, out_byte, is_data, last, output ready);
endinterface

interface orwp_csr_if;
   logic       valid;
   logic       ready;
   logic [6:0] column_offset;
   modport source (output valid, column_offset, input ready);
   modport sink   (input valid, column_offset, output ready);
endinterface

// ===== rtl/core/orwp_front.sv =====
// Front end: accepts requests, holds pixel count and pending nibble, builds queue jobs.
// Depends on orwp_pkg.
module orwp_front #(
   parameter int MAX_COLUMNS = orwp_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = orwp_pkg::MAX_ROWS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  logic                    cmd,
   input  logic [7:0]              x_first,
   input  logic [7:0]              x_last,
   input  logic [6:0]              y_first,
   input  logic [6:0]              y_last,
   input  logic [7:0]              pixel_value,
   input  logic                    csr_write,
   input  logic [6:0]              csr_data,
   output logic                    push,
   output orwp_pkg::orwp_entry_type push_entry
);
   import orwp_pkg::*;

   localparam logic [7:0] X_MAX = 8'(MAX_COLUMNS - 1);
   localparam logic [6:0] Y_MAX = 7'(MAX_ROWS - 1);

   logic [6:0]  column_offset_ff, column_offset_in;
   logic [15:0] pixels_left_ff, pixels_left_in;
   logic [3:0]  held_nibble_ff, held_nibble_in;
   logic        nibble_held_ff, nibble_held_in;

   logic [7:0]  xa, xb;
   logic [6:0]  ya, yb;
   logic [6:0]  groups;
   logic [8:0]  dx;
   logic [7:0]  dy;
   logic [16:0] area;
   logic        reversed;
   logic [3:0]  nib;

   always_comb begin
      xa = (x_first > X_MAX) ? X_MAX : x_first;
      xb = (x_last  > X_MAX) ? X_MAX : x_last;
      ya = (y_first > Y_MAX) ? Y_MAX : y_first;
      yb = (y_last  > Y_MAX) ? Y_MAX : y_last;
      groups   = {1'b0, xb[7:2]} - {1'b0, xa[7:2]} + 7'd1;
      dx       = {groups, 2'b00};
      dy       = {1'b0, yb} - {1'b0, ya} + 8'd1;
      area     = dx * dy;
      reversed = (xb[7:2] < xa[7:2]) || (yb < ya);
      nib      = pixel_value[7:4];
   end

   always_comb begin
      column_offset_in = csr_write ? csr_data : column_offset_ff;
      pixels_left_in   = pixels_left_ff;
      held_nibble_in   = held_nibble_ff;
      nibble_held_in   = nibble_held_ff;
      push             = 1'b0;
      push_entry.is_header = (cmd == CMD_REGION);
      push_entry.row_first = ya;
      push_entry.row_last  = yb;
      push_entry.col_first = 8'(column_offset_ff) + {2'b00, xa[7:2]};
      push_entry.col_last  = 8'(column_offset_ff) + {2'b00, xb[7:2]};
      push_entry.data_byte = {held_nibble_ff, nib};
      push_entry.last      = (pixels_left_ff == 16'd1);
      if (accept) begin
         if (cmd == CMD_REGION) begin
            push           = 1'b1;
            pixels_left_in = reversed ? 16'd0 : area[15:0];
            held_nibble_in = 4'd0;
            nibble_held_in = 1'b0;
         end else if (pixels_left_ff != 16'd0) begin
            pixels_left_in = pixels_left_ff - 16'd1;
            if (!nibble_held_ff) begin
               held_nibble_in = nib;
               nibble_held_in = 1'b1;
            end else begin
               push           = 1'b1;
               held_nibble_in = 4'd0;
               nibble_held_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_offset_ff <= COLUMN_OFFSET_RESET;
         pixels_left_ff   <= '0;
         held_nibble_ff   <= '0;
         nibble_held_ff   <= 1'b0;
      end else begin
         column_offset_ff <= column_offset_in;
         pixels_left_ff   <= pixels_left_in;
         held_nibble_ff   <= held_nibble_in;
         nibble_held_ff   <= nibble_held_in;
      end
   end

endmodule

// ===== rtl/core/orwp_queue.sv =====
// Short job queue between the front end and the byte sequencer.
// Depends on orwp_pkg.
module orwp_queue (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  orwp_pkg::orwp_entry_type push_entry,
   input  logic                     pop,
   output orwp_pkg::orwp_entry_type head,
   output orwp_pkg::orwp_qstat_type stat
);
   import orwp_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   orwp_entry_type   slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      stat.empty = (count_ff == '0);
      stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
      head       = slot_ff[rd_ptr_ff];
      wr_ptr_in  = push ? PTR_W'((wr_ptr_ff + 1'b1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in  = pop  ? PTR_W'((rd_ptr_ff + 1'b1) % QUEUE_DEPTH) : rd_ptr_ff;
      count_in   = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> (!stat.full || pop))
      else $error("queue push while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !stat.empty)
      else $error("queue pop while empty");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("queue count did not advance on push");

endmodule

// ===== rtl/core/orwp_back.sv =====
// Back end: expands queued jobs into response bytes behind an output register.
// Depends on orwp_pkg.
module orwp_back (
   input  logic                     clock,
   input  logic                     reset,
   input  orwp_pkg::orwp_entry_type head,
   input  orwp_pkg::orwp_qstat_type stat,
   output logic                     pop,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [7:0]               rsp_byte,
   output logic                     rsp_is_data,
   output logic                     rsp_last
);
   import orwp_pkg::*;

   hdr_step_type step_ff, step_in;
   logic         valid_ff, valid_in;
   logic [7:0]   byte_ff, byte_in;
   logic         is_data_ff, is_data_in;
   logic         last_ff, last_in;
   logic         load;
   logic [7:0]   hdr_byte;
   logic         hdr_is_data;
   hdr_step_type hdr_next;

   always_comb begin
      hdr_byte    = OP_ROW_WINDOW;
      hdr_is_data = 1'b0;
      hdr_next    = STEP_ROW_FIRST;
      case (step_ff)
         STEP_ROW_CMD: begin
            hdr_byte = OP_ROW_WINDOW; hdr_is_data = 1'b0; hdr_next = STEP_ROW_FIRST;
         end
         STEP_ROW_FIRST: begin
            hdr_byte = {1'b0, head.row_first}; hdr_is_data = 1'b1;
            hdr_next = STEP_ROW_LAST;
         end
         STEP_ROW_LAST: begin
            hdr_byte = {1'b0, head.row_last}; hdr_is_data = 1'b1;
            hdr_next = STEP_COL_CMD;
         end
         STEP_COL_CMD: begin
            hdr_byte = OP_COL_WINDOW; hdr_is_data = 1'b0; hdr_next = STEP_COL_FIRST;
         end
         STEP_COL_FIRST: begin
            hdr_byte = head.col_first; hdr_is_data = 1'b1; hdr_next = STEP_COL_LAST;
         end
         STEP_COL_LAST: begin
            hdr_byte = head.col_last; hdr_is_data = 1'b1; hdr_next = STEP_WRITE_RAM;
         end
         STEP_WRITE_RAM: begin
            hdr_byte = OP_WRITE_RAM; hdr_is_data = 1'b0; hdr_next = STEP_ROW_CMD;
         end
         default: begin
            hdr_byte = OP_ROW_WINDOW; hdr_is_data = 1'b0; hdr_next = STEP_ROW_CMD;
         end
      endcase

      load       = (!valid_ff || rsp_ready) && !stat.empty;
      step_in    = step_ff;
      valid_in   = valid_ff && !rsp_ready;
      byte_in    = byte_ff;
      is_data_in = is_data_ff;
      last_in    = last_ff;
      pop        = 1'b0;
      if (load) begin
         valid_in = 1'b1;
         if (head.is_header) begin
            byte_in    = hdr_byte;
            is_data_in = hdr_is_data;
            last_in    = 1'b0;
            step_in    = hdr_next;
            pop        = (step_ff == STEP_WRITE_RAM);
         end else begin
            byte_in    = head.data_byte;
            is_data_in = 1'b1;
            last_in    = head.last;
            pop        = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= STEP_ROW_CMD;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff    <= byte_in;
      is_data_ff <= is_data_in;
      last_ff    <= last_in;
   end

   assign rsp_valid   = valid_ff;
   assign rsp_byte    = byte_ff;
   assign rsp_is_data = is_data_ff;
   assign rsp_last    = last_ff;

endmodule

// ===== rtl/core/oled_region_write_packer.sv =====
// Top level of the OLED region write packer: front end, job queue, byte sequencer.
// Depends on orwp_pkg, orwp_if, orwp_front, orwp_queue, orwp_back.

// A region request (cmd 0) produces seven response bytes: row window command,
// first row, last row, column window command, offset plus first column group,
// offset plus last column group, and write RAM; it also loads a pixel count of
// width times height, with the column span widened to whole groups of four.
// Each pixel request (cmd 1) contributes its upper nibble; every second pixel
// yields one data byte, earlier pixel high, and the byte that empties the count
// has last set. Pixels with no count left are dropped. Requests are taken one
// per cycle while the four-entry job queue has room; the front end classifies
// and updates the count in the accept cycle. The back end sends one byte per
// cycle while rsp_ch.ready is high: a header job yields seven bytes, a data
// job one, so a steady pixel stream runs at one request per cycle while rsp_ch.ready stays high. The column
// offset csr is always ready and should be written only while the block is idle.
module oled_region_write_packer #(
   parameter int MAX_COLUMNS = orwp_pkg::MAX_COLUMNS_DEFAULT,
   parameter int MAX_ROWS    = orwp_pkg::MAX_ROWS_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   orwp_req_if.sink   req_ch,
   orwp_rsp_if.source rsp_ch,
   orwp_csr_if.sink   csr_ch
);
   import orwp_pkg::*;

   orwp_entry_type push_entry;
   orwp_entry_type head;
   orwp_qstat_type stat;
   logic           push;
   logic           pop;
   logic           accept;

   // Request taken whenever the queue can absorb a job
   assign req_ch.ready = !stat.full;
   assign accept       = req_ch.valid && req_ch.ready;

   // Column offset register lives in the front end; writes never stall
   assign csr_ch.ready = 1'b1;

   orwp_front #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_ROWS    (MAX_ROWS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .cmd         (req_ch.cmd),
      .x_first     (req_ch.x_first),
      .x_last      (req_ch.x_last),
      .y_first     (req_ch.y_first),
      .y_last      (req_ch.y_last),
      .pixel_value (req_ch.pixel_value),
      .csr_write   (csr_ch.valid),
      .csr_data    (csr_ch.column_offset),
      .push        (push),
      .push_entry  (push_entry)
   );

   orwp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .stat       (stat)
   );

   // Output register inside the back end holds each response byte; rsp_ch.ready still reaches pop directly
   orwp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .stat        (stat),
      .pop         (pop),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_byte    (rsp_ch.out_byte),
      .rsp_is_data (rsp_ch.is_data),
      .rsp_last    (rsp_ch.last)
   );

endmodule
